// ===== src/fade_boundary_generator_defines.svh =====
// Assertion macros for the fade boundary generator.
// Expects clk and arst_n in the scope of each use.
`ifndef FADE_BOUNDARY_GENERATOR_DEFINES_SVH
`define FADE_BOUNDARY_GENERATOR_DEFINES_SVH

// same-cycle implication
`define FBG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FBG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/fbg_pkg.sv =====
// Shared types and constants of the fade boundary generator.
// No dependencies.
package fbg_pkg;

	localparam int unsigned SR_W       = 20;
	localparam int unsigned FADE_W     = 12;
	localparam int unsigned POS_W      = 64;
	localparam int unsigned ID_W       = 32;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned QDEPTH     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FADES_EN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_ID    = 2'd2;

	localparam logic [SR_W-1:0] SR_RESET = 20'd48000;

	localparam int unsigned FADE_MS     = 3;
	localparam int unsigned ROUND_HALF  = 500;
	localparam int unsigned MS_PER_S    = 1000;
	localparam int unsigned RECIP_SHIFT = 32;
	localparam int unsigned X_W         = SR_W + 2;
	localparam int unsigned RECIP_W     = 23;
	localparam logic [RECIP_W-1:0] RECIP_1000 =
		RECIP_W'((64'd1 << RECIP_SHIFT) / MS_PER_S + 1);

	typedef struct packed {
		logic             close_old;
		logic             old_gap;
		logic [POS_W-1:0] old_pos;
		logic [POS_W-1:0] old_len;
		logic             last;
		logic             cur_gap;
		logic [POS_W-1:0] cur_pos;
		logic [POS_W-1:0] cur_len;
		logic [POS_W-1:0] end_pos;
	} job_t;

	// round(sr * 3 / 1000) via reciprocal multiply, exact for all 20-bit rates
	function automatic logic [FADE_W-1:0] fade_default(input logic [SR_W-1:0] sr);
		logic [X_W-1:0]             x;
		logic [X_W+RECIP_W-1:0]     prod;
		x    = X_W'(sr) * X_W'(FADE_MS) + X_W'(ROUND_HALF);
		prod = (X_W+RECIP_W)'(x) * (X_W+RECIP_W)'(RECIP_1000);
		return prod[RECIP_SHIFT +: FADE_W];
	endfunction

endpackage

// ===== src/fbg_front.sv =====
// Front end: accepts spans, tracks the current run and issues close jobs.
// Depends on fbg_pkg.
module fbg_front import fbg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    is_gap,
	input  logic signed [POS_W-1:0] span_start,
	input  logic signed [POS_W-1:0] span_length,
	input  logic signed [POS_W-1:0] source_offset,
	input  logic [ID_W-1:0]         asset_ref,
	input  logic [ID_W-1:0]         media_gen,
	input  logic [ID_W-1:0]         units_numer,
	input  logic [ID_W-1:0]         units_denom,
	input  logic                    last_span,
	input  logic                    q_full,
	output logic                    push,
	output job_t                    job
);

	logic             run_active_q;
	logic             run_gap_q;
	logic [POS_W-1:0] run_start_q;
	logic [POS_W-1:0] run_len_q;
	logic [POS_W-1:0] run_src_q;
	logic [POS_W-1:0] run_end_q;
	logic [POS_W-1:0] src_end_q;
	logic [ID_W-1:0]  asset_q;
	logic [ID_W-1:0]  gen_q;
	logic [ID_W-1:0]  numer_q;
	logic [ID_W-1:0]  denom_q;

	logic             accept;
	logic             len_ok;
	logic             cont;
	logic [POS_W-1:0] end_sum;
	logic [POS_W-1:0] src_sum;
	logic [POS_W-1:0] len_next;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		len_ok = !run_len_q[POS_W-1] && (run_len_q != '0);
		// run_end_q / src_end_q hold start+len and source+len of the run
		cont = run_active_q && !run_gap_q && !is_gap && len_ok
			&& !run_start_q[POS_W-1] && !run_src_q[POS_W-1]
			&& !run_end_q[POS_W-1] && !src_end_q[POS_W-1]
			&& (run_end_q == span_start) && (src_end_q == source_offset)
			&& (asset_q == asset_ref) && (gen_q == media_gen)
			&& (numer_q == units_numer) && (denom_q == units_denom);
		end_sum  = span_start + span_length;
		src_sum  = source_offset + span_length;
		len_next = cont ? (run_len_q + span_length) : span_length;

		job.close_old = !cont && run_active_q;
		job.old_gap   = run_gap_q;
		job.old_pos   = run_start_q;
		job.old_len   = run_len_q;
		job.last      = last_span;
		job.cur_gap   = is_gap;
		job.cur_pos   = cont ? run_start_q : span_start;
		job.cur_len   = len_next;
		job.end_pos   = end_sum;
		push = accept && (job.close_old || last_span);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_active_q <= 1'b0;
		end else if (accept) begin
			run_active_q <= !last_span;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			run_len_q <= len_next;
			run_end_q <= end_sum;
			src_end_q <= src_sum;
			if (!cont) begin
				run_gap_q   <= is_gap;
				run_start_q <= span_start;
				run_src_q   <= source_offset;
				asset_q     <= asset_ref;
				gen_q       <= media_gen;
				numer_q     <= units_numer;
				denom_q     <= units_denom;
			end
		end
	end

endmodule

// ===== src/fbg_queue.sv =====
// Short job queue between front and back end.
// Depends on fbg_pkg.
module fbg_queue import fbg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t rd_job
);

	localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	job_t            mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full   = (count_q == CW'(QDEPTH));
	assign empty  = (count_q == '0);
	assign rd_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

endmodule

// ===== src/fbg_back.sv =====
// Back end: turns close jobs into up to three boundary beats.
// Depends on fbg_pkg.
module fbg_back import fbg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_empty,
	input  job_t                    q_job,
	output logic                    q_pop,
	input  logic [FADE_W-1:0]       def_fade,
	input  logic                    fades_en,
	input  logic [ID_W-1:0]         track_cfg,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ID_W-1:0]         boundary_track,
	output logic signed [POS_W-1:0] boundary_pos,
	output logic [FADE_W-1:0]       fade_before,
	output logic [FADE_W-1:0]       fade_after,
	output logic                    last_of_run
);

	localparam int unsigned NCAND = 3;

	function automatic logic [FADE_W-1:0] tail_fade(input logic gap,
		input logic [POS_W-1:0] len, input logic [FADE_W-1:0] dflt);
		logic [POS_W-2:0] half;
		half = len[POS_W-1:1];
		if (gap || len[POS_W-1] || (len == '0)) begin
			return '0;
		end
		if (half[POS_W-2:FADE_W] != '0) begin
			return dflt;
		end
		return (half[FADE_W-1:0] < dflt) ? half[FADE_W-1:0] : dflt;
	endfunction

	logic [NCAND-1:0]  pend_q;
	logic [POS_W-1:0]  cpos_q [NCAND];
	logic [FADE_W-1:0] cbef_q [NCAND];
	logic [FADE_W-1:0] caft_q [NCAND];
	logic [FADE_W-1:0] prev_q;

	logic              out_valid_q;
	logic [ID_W-1:0]   track_q;
	logic [POS_W-1:0]  pos_q;
	logic [FADE_W-1:0] bef_q;
	logic [FADE_W-1:0] aft_q;
	logic              lor_q;

	logic              out_free;
	logic              issue;
	logic [1:0]        idx;
	logic [NCAND-1:0]  sel_oh;
	logic [NCAND-1:0]  pend_left;
	logic              load;
	logic [FADE_W-1:0] t_old;
	logic [FADE_W-1:0] t_cur;
	logic [FADE_W-1:0] p1;
	logic [NCAND-1:0]  new_pend;
	logic [FADE_W-1:0] prev_next;

	always_comb begin
		out_free = !out_valid_q || out_ready;
		issue    = out_free && (pend_q != '0);
		priority if (pend_q[0]) begin
			idx = 2'd0;
		end else if (pend_q[1]) begin
			idx = 2'd1;
		end else begin
			idx = 2'd2;
		end
		sel_oh    = NCAND'(1) << idx;
		pend_left = pend_q & ~sel_oh;
		load      = !q_empty && ((pend_q == '0) || (issue && (pend_left == '0)));

		t_old = tail_fade(q_job.old_gap, q_job.old_len, def_fade);
		t_cur = tail_fade(q_job.cur_gap, q_job.cur_len, def_fade);
		p1    = q_job.close_old ? t_old : prev_q;
		new_pend[0] = q_job.close_old && ((prev_q != '0) || (t_old != '0));
		new_pend[1] = q_job.last && ((p1 != '0) || (t_cur != '0));
		new_pend[2] = q_job.last && (t_cur != '0);
		if (!fades_en) begin
			new_pend = '0;
		end
		prev_next = q_job.last ? '0 : p1;
	end

	assign q_pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			prev_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				pend_q <= new_pend;
				prev_q <= prev_next;
			end else if (issue) begin
				pend_q <= pend_left;
			end
			if (issue) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cpos_q[0] <= q_job.old_pos;
			cbef_q[0] <= prev_q;
			caft_q[0] <= t_old;
			cpos_q[1] <= q_job.cur_pos;
			cbef_q[1] <= p1;
			caft_q[1] <= t_cur;
			cpos_q[2] <= q_job.end_pos;
			cbef_q[2] <= t_cur;
			caft_q[2] <= '0;
		end
		if (issue) begin
			track_q <= track_cfg;
			pos_q   <= cpos_q[idx];
			bef_q   <= cbef_q[idx];
			aft_q   <= caft_q[idx];
			lor_q   <= (pend_left == '0);
		end
	end

	assign out_valid      = out_valid_q;
	assign boundary_track = track_q;
	assign boundary_pos   = pos_q;
	assign fade_before    = bef_q;
	assign fade_after     = aft_q;
	assign last_of_run    = lor_q;

endmodule

// ===== src/fade_boundary_generator.sv =====
// Fade boundary generator, top level.
// Spans of one track enter on in_valid/in_ready, one beat per span, in timeline
// order; last_span marks the final span. Boundaries leave on out_valid/out_ready,
// at most three beats per span, last_of_run set on the final beat a span causes.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data
// (0 sample rate, 1 fades enable, 2 track id); cfg_ready is always high. The user
// must make writes only while the block is idle; the block does not enforce this.
// A span's job goes through the job queue, the candidate registers and the output register.
// Throughput: one span per cycle in while the two-entry job queue has room,
// one boundary per cycle out while out_ready is high.
// Reset clears the run state, the queue and the output register and loads the
// register defaults (48 kHz, fades on, track 0).
// When the receiver stalls, the output register holds, the back end stops, the
// queue fills and in_ready drops.
// Depends on fbg_pkg, fbg_front, fbg_queue, fbg_back and the defines header.
`include "fade_boundary_generator_defines.svh"

module fade_boundary_generator import fbg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    is_gap,
	input  logic signed [POS_W-1:0] span_start,
	input  logic signed [POS_W-1:0] span_length,
	input  logic signed [POS_W-1:0] source_offset,
	input  logic [ID_W-1:0]         asset_ref,
	input  logic [ID_W-1:0]         media_gen,
	input  logic [ID_W-1:0]         units_numer,
	input  logic [ID_W-1:0]         units_denom,
	input  logic                    last_span,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [ID_W-1:0]         boundary_track,
	output logic signed [POS_W-1:0] boundary_pos,
	output logic [FADE_W-1:0]       fade_before,
	output logic [FADE_W-1:0]       fade_after,
	output logic                    last_of_run
);

	logic [SR_W-1:0]   sample_rate_q;
	logic              fades_en_q;
	logic [ID_W-1:0]   track_id_q;
	logic [FADE_W-1:0] def_q;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	job_t wr_job;
	job_t rd_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= SR_RESET;
			fades_en_q    <= 1'b1;
			track_id_q    <= '0;
			def_q         <= fade_default(SR_RESET);
		end else begin
			def_q <= fade_default(sample_rate_q);
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SAMPLE_RATE: sample_rate_q <= cfg_data[SR_W-1:0];
					REG_FADES_EN:    fades_en_q    <= cfg_data[0];
					REG_TRACK_ID:    track_id_q    <= cfg_data[ID_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	fbg_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.is_gap        (is_gap),
		.span_start    (span_start),
		.span_length   (span_length),
		.source_offset (source_offset),
		.asset_ref     (asset_ref),
		.media_gen     (media_gen),
		.units_numer   (units_numer),
		.units_denom   (units_denom),
		.last_span     (last_span),
		.q_full        (q_full),
		.push          (q_push),
		.job           (wr_job)
	);

	fbg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_job (wr_job),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rd_job (rd_job)
	);

	fbg_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_empty        (q_empty),
		.q_job          (rd_job),
		.q_pop          (q_pop),
		.def_fade       (def_q),
		.fades_en       (fades_en_q),
		.track_cfg      (track_id_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.boundary_track (boundary_track),
		.boundary_pos   (boundary_pos),
		.fade_before    (fade_before),
		.fade_after     (fade_after),
		.last_of_run    (last_of_run)
	);

	`FBG_ASSERT_SAME(a_fade_nonzero, out_valid, (fade_before != '0) || (fade_after != '0), "boundary beat with both fades zero")
	`FBG_ASSERT_SAME(a_fade_bound, out_valid, (fade_before <= def_q) && (fade_after <= def_q), "fade exceeds default length")
	`FBG_ASSERT_SAME(a_queue_room, q_push, !q_full, "job pushed into full queue")
	`FBG_ASSERT_NEXT(a_disabled_silent, !fades_en_q && !out_valid, !out_valid, "boundary while fades disabled")

endmodule

// ===== bench/fbg_checker.sv =====
`timescale 1ns / 1ps
// Boundary checker for the fade boundary generator: watches the register, span and
// boundary channels, predicts every boundary and compares it beat by beat.
// Depends on fbg_pkg.
module fbg_checker import fbg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  is_gap,
	input  logic [POS_W-1:0]      span_start,
	input  logic [POS_W-1:0]      span_length,
	input  logic [POS_W-1:0]      source_offset,
	input  logic [ID_W-1:0]       asset_ref,
	input  logic [ID_W-1:0]       media_gen,
	input  logic [ID_W-1:0]       units_numer,
	input  logic [ID_W-1:0]       units_denom,
	input  logic                  last_span,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [ID_W-1:0]       boundary_track,
	input  logic [POS_W-1:0]      boundary_pos,
	input  logic [FADE_W-1:0]     fade_before,
	input  logic [FADE_W-1:0]     fade_after,
	input  logic                  last_of_run,
	output int                    mismatches,
	output int                    pending,
	output int                    boundaries_checked
);

	localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};

	typedef struct packed {
		logic [ID_W-1:0]   track;
		logic [POS_W-1:0]  pos;
		logic [FADE_W-1:0] fade_out;
		logic [FADE_W-1:0] fade_in;
		logic              closes;
	} boundary_t;

	boundary_t expected_q[$];
	boundary_t span_boundaries[$];

	logic [SR_W-1:0]   rate;
	logic              fades_on;
	logic [ID_W-1:0]   track;

	logic              run_on;
	logic              run_silent;
	logic [POS_W-1:0]  r_start;
	logic [POS_W-1:0]  r_len;
	logic [POS_W-1:0]  r_src;
	logic [ID_W-1:0]   r_asset;
	logic [ID_W-1:0]   r_gen;
	logic [ID_W-1:0]   r_numer;
	logic [ID_W-1:0]   r_denom;
	logic [FADE_W-1:0] owed_fade;

	// fade owed by the current run: default length, at most half the run, none for gaps or non-positive lengths
	function automatic logic [FADE_W-1:0] run_fade_len();
		logic [POS_W-1:0] dflt;
		logic [POS_W-1:0] half;
		dflt = (POS_W'(rate) * FADE_MS + ROUND_HALF) / MS_PER_S;
		if (run_silent || r_len[POS_W-1] || r_len == '0)
			return '0;
		half = r_len >> 1;
		return FADE_W'((half < dflt) ? half : dflt);
	endfunction

	function automatic void add_boundary(logic [POS_W-1:0] pos, logic [FADE_W-1:0] f_out,
			logic [FADE_W-1:0] f_in);
		boundary_t b;
		if (f_out == '0 && f_in == '0)
			return;
		b = '{track, pos, f_out, f_in, 1'b0};
		span_boundaries = {span_boundaries, b};
	endfunction

	function automatic void close_run();
		logic [FADE_W-1:0] f_in;
		f_in = run_fade_len();
		add_boundary(r_start, owed_fade, f_in);
		owed_fade = f_in;
	endfunction

	function automatic void predict_span();
		logic seamless;
		seamless = run_on && !run_silent && !is_gap
			&& !r_len[POS_W-1] && r_len != '0
			&& !r_start[POS_W-1] && !r_src[POS_W-1]
			&& r_len <= POS_MAX - r_start && r_len <= POS_MAX - r_src
			&& r_start + r_len == span_start && r_src + r_len == source_offset
			&& r_asset == asset_ref && r_gen == media_gen
			&& r_numer == units_numer && r_denom == units_denom;
		span_boundaries.delete();
		if (seamless) begin
			r_len = r_len + span_length;
		end else begin
			if (run_on)
				close_run();
			run_on     = 1'b1;
			run_silent = is_gap;
			r_start    = span_start;
			r_len      = span_length;
			r_src      = source_offset;
			r_asset    = asset_ref;
			r_gen      = media_gen;
			r_numer    = units_numer;
			r_denom    = units_denom;
		end
		if (last_span) begin
			close_run();
			add_boundary(r_start + r_len, owed_fade, '0);
			run_on    = 1'b0;
			owed_fade = '0;
		end
		if (fades_on && span_boundaries.size() > 0) begin
			span_boundaries[span_boundaries.size()-1].closes = 1'b1;
			expected_q = {expected_q, span_boundaries};
		end
	endfunction

	function automatic void check_beat();
		boundary_t want;
		boundaries_checked++;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t: unexpected boundary pos %h fade %0d/%0d", $realtime,
					boundary_pos, fade_before, fade_after);
			return;
		end
		want = expected_q.pop_front();
		if (boundary_track !== want.track || boundary_pos !== want.pos
				|| fade_before !== want.fade_out || fade_after !== want.fade_in
				|| last_of_run !== want.closes) begin
			mismatches++;
			if (mismatches <= 10) begin
				$write("%t: boundary %0d exp/got track %h/%h pos %h/%h ",
					$realtime, boundaries_checked, want.track, boundary_track,
					want.pos, boundary_pos);
				$display("fade_before %0d/%0d fade_after %0d/%0d last %b/%b",
					want.fade_out, fade_before, want.fade_in, fade_after,
					want.closes, last_of_run);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate       = SR_RESET;
			fades_on   = 1'b1;
			track      = '0;
			run_on     = 1'b0;
			run_silent = 1'b0;
			r_start    = '0;
			r_len      = '0;
			r_src      = '0;
			r_asset    = '0;
			r_gen      = '0;
			r_numer    = '0;
			r_denom    = '0;
			owed_fade  = '0;
			expected_q.delete();
			mismatches         = 0;
			boundaries_checked = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_beat();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SAMPLE_RATE: rate = cfg_data[SR_W-1:0];
					REG_FADES_EN:    fades_on = cfg_data[0];
					REG_TRACK_ID:    track = cfg_data[ID_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				predict_span();
			pending <= expected_q.size();
		end
	end

endmodule

// ===== bench/tb_fade_boundary_generator.sv =====
`timescale 1ns / 1ps
// Top of the fade boundary generator bench: drives spans and register writes,
// idles both sides, and reports the verdict. Depends on fbg_pkg, fbg_checker
// and the fade_boundary_generator RTL.
module tb_fade_boundary_generator;
	import fbg_pkg::*;

	localparam logic [POS_W-1:0] POS_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [POS_W-1:0] HALF_SPAN = 64'h4000_0000_0000_0000;
	localparam logic [POS_W-1:0] SIGN_POS  = 64'h8000_0000_0000_0000;
	localparam int SETTLE_CYCLES = 8;
	localparam int NUM_SETTINGS  = 6;

	typedef struct {
		logic             gap;
		logic [POS_W-1:0] start;
		logic [POS_W-1:0] len;
		logic [POS_W-1:0] src;
		logic [ID_W-1:0]  asset;
		logic [ID_W-1:0]  gen;
		logic [ID_W-1:0]  numer;
		logic [ID_W-1:0]  denom;
		logic             ends_track;
	} span_t;

	logic                    clk;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic                    is_gap = 1'b0;
	logic signed [POS_W-1:0] span_start = '0;
	logic signed [POS_W-1:0] span_length = '0;
	logic signed [POS_W-1:0] source_offset = '0;
	logic [ID_W-1:0]         asset_ref = '0;
	logic [ID_W-1:0]         media_gen = '0;
	logic [ID_W-1:0]         units_numer = '0;
	logic [ID_W-1:0]         units_denom = '0;
	logic                    last_span = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [ID_W-1:0]         boundary_track;
	logic signed [POS_W-1:0] boundary_pos;
	logic [FADE_W-1:0]       fade_before;
	logic [FADE_W-1:0]       fade_after;
	logic                    last_of_run;

	int mismatches;
	int pending;
	int boundaries_checked;
	int send_idle = 29;
	int recv_idle = 86;
	int spans_sent = 0;
	int settings_used = 1;

	logic [SR_W-1:0] rate_tab[NUM_SETTINGS]  = '{20'd1000000, 20'd1, 20'd44100, 20'd167,
		20'd8000, 20'd96000};
	logic            fades_tab[NUM_SETTINGS] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
	int              count_tab[NUM_SETTINGS] = '{55, 20, 20, 55, 55, 60};

	fade_boundary_generator u_dut (.*);

	fbg_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAILURE");
		$finish;
	end

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle);

	function automatic logic [POS_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic span_t mk(logic gap, logic [POS_W-1:0] start, logic [POS_W-1:0] len,
			logic [POS_W-1:0] src, logic ends_track);
		span_t s;
		s.gap        = gap;
		s.start      = start;
		s.len        = len;
		s.src        = src;
		s.asset      = 32'h0000_00A5;
		s.gen        = 32'd1;
		s.numer      = 32'd1;
		s.denom      = 32'd48000;
		s.ends_track = ends_track;
		return s;
	endfunction

	function automatic logic [POS_W-1:0] pick_len();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return POS_W'($urandom_range(1, 2000));
		else if (r < 70)
			return POS_W'($urandom_range(2000, 1000000));
		else if (r < 76)
			return '0;
		else if (r < 82)
			return 64'd1;
		else if (r < 88)
			return -POS_W'($urandom_range(1, 1000));
		else if (r < 94)
			return rand64();
		return HALF_SPAN + POS_W'($urandom_range(0, 100));
	endfunction

	task automatic send_span(span_t s);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		is_gap        <= s.gap;
		span_start    <= s.start;
		span_length   <= s.len;
		source_offset <= s.src;
		asset_ref     <= s.asset;
		media_gen     <= s.gen;
		units_numer   <= s.numer;
		units_denom   <= s.denom;
		last_span     <= s.ends_track;
		do @(posedge clk); while (!in_ready);
		spans_sent++;
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_setting(logic [SR_W-1:0] rate, logic fades, logic [ID_W-1:0] track);
		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_SAMPLE_RATE, CFG_DATA_W'(rate));
		write_reg(REG_FADES_EN, CFG_DATA_W'(fades));
		write_reg(REG_TRACK_ID, CFG_DATA_W'(track));
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic run_directed();
		span_t s;
		send_span(mk(1'b1, 0, 480, 0, 1'b1));
		send_span(mk(1'b0, 100, 1000, 0, 1'b0));
		send_span(mk(1'b0, 1100, 500, 1000, 1'b0));
		send_span(mk(1'b0, 1600, 200, 1500, 1'b1));
		send_span(mk(1'b0, 0, 1000, 0, 1'b0));
		// abutting spans that differ in one identity field each
		s = mk(1'b0, 1000, 1000, 1000, 1'b0);
		s.asset = ~s.asset;
		send_span(s);
		s = mk(1'b0, 2000, 1000, 2000, 1'b0);
		s.asset = ~s.asset;
		s.gen = 32'd2;
		send_span(s);
		s.start = 3000;
		s.src = 3000;
		s.numer = 32'd3;
		send_span(s);
		s.start = 4000;
		s.src = 4000;
		s.denom = 32'd44100;
		send_span(s);
		send_span(mk(1'b1, 5000, 300, 0, 1'b0));
		send_span(mk(1'b0, 5300, 1, 0, 1'b1));
		send_span(mk(1'b0, 0, 0, 0, 1'b0));
		send_span(mk(1'b0, 0, -64'd5, 0, 1'b0));
		// run end past the signed maximum
		send_span(mk(1'b0, POS_MAX - 10, 20, 0, 1'b0));
		send_span(mk(1'b0, POS_MAX + 10, 20, 20, 1'b1));
		send_span(mk(1'b0, -64'd1000, 1000, 0, 1'b0));
		send_span(mk(1'b0, 0, 1000, 1000, 1'b0));
		send_span(mk(1'b0, 1000, 1000, -64'd1000, 1'b0));
		send_span(mk(1'b0, 2000, 1000, 0, 1'b1));
		// merged length wraps into the sign bit
		send_span(mk(1'b0, 0, HALF_SPAN, 0, 1'b0));
		send_span(mk(1'b0, HALF_SPAN, HALF_SPAN, HALF_SPAN, 1'b0));
		send_span(mk(1'b0, SIGN_POS, 100, SIGN_POS, 1'b1));
		s = mk(1'b0, POS_MAX, POS_MAX, POS_MAX, 1'b1);
		s.asset = '1;
		s.gen = '1;
		s.numer = '1;
		s.denom = '1;
		send_span(s);
		s = mk(1'b1, '1, '1, '1, 1'b1);
		s.asset = '1;
		s.gen = '1;
		s.numer = '1;
		s.denom = '1;
		send_span(s);
	endtask

	// one track: mostly seamless runs with random content, some breaks and noise
	task automatic play_track();
		int unsigned n;
		int unsigned r;
		span_t s;
		logic [POS_W-1:0] next_pos;
		logic [POS_W-1:0] next_src;
		logic [ID_W-1:0] asset, gen, numer, denom;
		n = $urandom_range(1, 7);
		r = $urandom_range(99);
		if (r < 80)
			next_pos = POS_W'($urandom_range(0, 1000000));
		else if (r < 90)
			next_pos = 64'h7FFF_FFFF_FFFF_0000 + POS_W'($urandom_range(0, 65535));
		else
			next_pos = rand64();
		next_src = POS_W'($urandom_range(0, 100000));
		asset = $urandom;
		gen   = $urandom_range(0, 3);
		numer = $urandom_range(1, 48000);
		denom = $urandom_range(1, 48000);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			s.gap = 1'b0;
			s.start = next_pos;
			s.src = next_src;
			s.len = pick_len();
			if (r >= 55 && r < 70) begin
				s.gap = 1'b1;
			end else if (r >= 70 && r < 80) begin
				asset = $urandom;
				s.src = POS_W'($urandom_range(0, 1000000));
			end else if (r >= 80 && r < 88) begin
				case ($urandom_range(2))
					0: gen = gen + 1;
					1: numer = numer + 1;
					default: denom = denom + 1;
				endcase
			end else if (r >= 88 && r < 94) begin
				if ($urandom_range(1))
					s.start = s.start + 1;
				else
					s.src = s.src - 1;
			end
			s.asset = asset;
			s.gen = gen;
			s.numer = numer;
			s.denom = denom;
			if (r >= 94) begin
				s.gap = 1'($urandom_range(1));
				s.start = rand64();
				s.len = rand64();
				s.src = rand64();
				s.asset = $urandom;
				s.gen = $urandom;
				s.numer = $urandom;
				s.denom = $urandom;
			end
			s.ends_track = (k == n - 1);
			send_span(s);
			next_pos = s.start + s.len;
			next_src = s.src + s.len;
		end
	endtask

	initial begin
		int target;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		for (int seg = 0; seg < NUM_SETTINGS; seg++) begin
			load_setting(rate_tab[seg], fades_tab[seg],
				(seg == 0) ? 32'hFFFF_FFFF : (seg == 1) ? 32'h0 : $urandom);
			case (seg / 2)
				0: begin
					send_idle = 29;
					recv_idle = 86;
				end
				1: begin
					send_idle = 86;
					recv_idle = 29;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			target = spans_sent + count_tab[seg];
			while (spans_sent < target) begin
				play_track();
				if ($urandom_range(9) == 0)
					hold_until_drained();
			end
		end
		hold_until_drained();
		repeat (20) @(posedge clk);
		$display("Run covered %0d spans over %0d register settings, idling on either side",
			spans_sent, settings_used);
		$display("and on neither; %0d boundaries checked, %0d mismatches.",
			boundaries_checked, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
